// ----- src/cfd_pkg.sv -----
// ----------------------------------------------------------------------------
// cfd_pkg: shared types and constants of the circular delay flanger
// Sample, register and position widths, register indexes and the request
// and response bundles of the step reduction unit.
// ----------------------------------------------------------------------------
package cfd_pkg;

	localparam int MAX_DELAY   = 1024;
	localparam int ADDR_BITS   = 10;
	localparam int LEN_BITS    = 11;
	localparam int SAMPLE_BITS = 24;
	localparam int FRAC_BITS   = 16;
	localparam int GAIN_FRAC   = 12;
	localparam int STEP_BITS   = 27;
	localparam int GAIN_BITS   = 16;
	localparam int POS_BITS    = ADDR_BITS + FRAC_BITS;
	localparam int INT_BITS    = STEP_BITS - FRAC_BITS;
	localparam int CFG_BITS    = 27;
	localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS;
	localparam int WET_BITS    = PROD_BITS - GAIN_FRAC;
	localparam int CNT_BITS    = 4;

	localparam logic [LEN_BITS-1:0]  LEN_RESET  = 11'd960;
	localparam logic [STEP_BITS-1:0] STEP_RESET = 27'd65536;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef enum logic [1:0] {
		REG_LENGTH = 2'd0,
		REG_STEP   = 2'd1,
		REG_GAIN   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic                       start;
		logic [LEN_BITS-1:0]        len;
		logic signed [INT_BITS-1:0] num;
	} mod_req_t;

	typedef struct packed {
		logic                 busy;
		logic [ADDR_BITS-1:0] rem;
	} mod_rsp_t;

endpackage

// ----- src/cfd_in_if.sv -----
// ----------------------------------------------------------------------------
// cfd_in_if: input sample channel
// Valid/ready channel that carries one audio sample per request.
// ----------------------------------------------------------------------------
interface cfd_in_if;
	import cfd_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);

endinterface

// ----- src/cfd_out_if.sv -----
// ----------------------------------------------------------------------------
// cfd_out_if: output sample channel
// Valid/ready channel that carries one processed sample per request.
// ----------------------------------------------------------------------------
interface cfd_out_if;
	import cfd_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);

endinterface

// ----- src/circular_delay_flanger.sv -----
// ----------------------------------------------------------------------------
// circular_delay_flanger: flanger built on a circular delay store
// Writes each sample at the write index, reads at the integer part of a
// fractional read position and mixes dry plus delayed times depth gain.
//
//   channel  dir  payload            handshake
//   feed     in   sample_in  [23:0]  valid & ready
//   result   out  sample_out [23:0]  valid & ready
//   cfg      in   cfg_index/cfg_data cfg_we, no wait
//
// One sample per cycle while feed.ready is high; each sample passes through
// the store read, multiply, and mix and saturate stages. Unwritten entries
// read as zero through a high-water mark, so no clearing pass is needed.
// After reset and after each write of delay_length or read_step, feed.ready
// stays low while the step is reduced modulo the length. Stalls on result
// fill the pipeline stages before feed.ready drops.
// ----------------------------------------------------------------------------
module circular_delay_flanger (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [cfd_pkg::CFG_BITS-1:0]  cfg_data,
	cfd_in_if.sink                        feed,
	cfd_out_if.source                     result
);
	import cfd_pkg::*;

	logic [LEN_BITS-1:0]         len_q;
	logic [STEP_BITS-1:0]        step_q;
	logic signed [GAIN_BITS-1:0] gain_q;
	logic                        start_q;
	logic [ADDR_BITS-1:0]        wi_q;
	logic [LEN_BITS-1:0]         hw_q;
	logic [POS_BITS-1:0]         rp_q;

	logic [LEN_BITS-1:0] len_clamped;
	mod_req_t            mreq;
	mod_rsp_t            mrsp;
	logic                busy;
	logic                accept;
	logic [ADDR_BITS-1:0] ridx;
	logic [POS_BITS-1:0]  step_red;
	logic [POS_BITS:0]    pos_sum;
	logic [POS_BITS:0]    span;
	logic [POS_BITS:0]    pos_wrap;
	logic [LEN_BITS-1:0]  wi_inc;

	sample_t mem [MAX_DELAY];

	logic                        v_s1;
	sample_t                     dry_s1;
	sample_t                     rdata_s1;
	logic                        fwd_s1;
	logic                        zero_s1;
	logic                        v_s2;
	sample_t                     dry_s2;
	logic signed [PROD_BITS-1:0] prod_s2;
	logic                        out_v_q;
	sample_t                     out_q;

	logic                        out_en;
	logic                        s2_en;
	logic                        s1_en;
	sample_t                     delayed;
	logic signed [PROD_BITS-1:0] prod;
	logic signed [WET_BITS-1:0]  wet;
	logic signed [WET_BITS:0]    mix;
	sample_t                     mix_sat;

	// ---------------- configuration ----------------
	always_comb begin
		len_clamped = cfg_data[LEN_BITS-1:0];
		if (len_clamped == '0) begin
			len_clamped = LEN_BITS'(1);
		end else if (len_clamped > LEN_BITS'(MAX_DELAY)) begin
			len_clamped = LEN_BITS'(MAX_DELAY);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= LEN_RESET;
			step_q  <= STEP_RESET;
			gain_q  <= '0;
			start_q <= 1'b1;
		end else begin
			start_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_LENGTH: begin
						len_q   <= len_clamped;
						start_q <= 1'b1;
					end
					REG_STEP: begin
						step_q  <= cfg_data[STEP_BITS-1:0];
						start_q <= 1'b1;
					end
					REG_GAIN: begin
						gain_q <= cfg_data[GAIN_BITS-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign mreq.start = start_q;
	assign mreq.len   = len_q;
	assign mreq.num   = step_q[STEP_BITS-1:FRAC_BITS];

	cfd_step_mod u_step_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	assign busy     = start_q | mrsp.busy;
	assign step_red = {mrsp.rem, step_q[FRAC_BITS-1:0]};

	// ---------------- pipeline control ----------------
	assign out_en     = !out_v_q || result.ready;
	assign s2_en      = !v_s2 || out_en;
	assign s1_en      = !v_s1 || s2_en;
	assign feed.ready = s1_en && !busy;
	assign accept     = feed.valid && feed.ready;

	// ---------------- positions ----------------
	assign ridx     = rp_q[POS_BITS-1:FRAC_BITS];
	assign pos_sum  = {1'b0, rp_q} + {1'b0, step_red};
	assign span     = {len_q, {FRAC_BITS{1'b0}}};
	assign pos_wrap = (pos_sum >= span) ? (pos_sum - span) : pos_sum;
	assign wi_inc   = {1'b0, wi_q} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q <= '0;
			rp_q <= '0;
			hw_q <= '0;
		end else if (cfg_we && cfg_index == REG_LENGTH) begin
			wi_q <= '0;
			rp_q <= '0;
		end else if (accept) begin
			wi_q <= (wi_inc >= len_q) ? '0 : wi_inc[ADDR_BITS-1:0];
			rp_q <= pos_wrap[POS_BITS-1:0];
			// writes run upward from zero, so the written entries form a prefix
			if ({1'b0, wi_q} == hw_q) begin
				hw_q <= hw_q + 1'b1;
			end
		end
	end

	// ---------------- delay store ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			mem[wi_q] <= feed.sample_in;
		end
		if (s1_en) begin
			rdata_s1 <= mem[ridx];
		end
	end

	// ---------------- stage 1: store read ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_en) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en) begin
			dry_s1  <= feed.sample_in;
			fwd_s1  <= (ridx == wi_q);
			zero_s1 <= ({1'b0, ridx} >= hw_q);
		end
	end

	// ---------------- stage 2: multiply ----------------
	always_comb begin
		if (fwd_s1) begin
			delayed = dry_s1;
		end else if (zero_s1) begin
			delayed = '0;
		end else begin
			delayed = rdata_s1;
		end
	end

	assign prod = delayed * gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_en) begin
			dry_s2  <= dry_s1;
			prod_s2 <= prod;
		end
	end

	// ---------------- output: mix and saturate ----------------
	assign wet = prod_s2[PROD_BITS-1:GAIN_FRAC];
	assign mix = (WET_BITS+1)'(dry_s2) + (WET_BITS+1)'(wet);

	always_comb begin
		if (mix > (WET_BITS+1)'(sample_t'({1'b0, {(SAMPLE_BITS-1){1'b1}}}))) begin
			mix_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end else if (mix < (WET_BITS+1)'(sample_t'({1'b1, {(SAMPLE_BITS-1){1'b0}}}))) begin
			mix_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			mix_sat = mix[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_en) begin
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en) begin
			out_q <= mix_sat;
		end
	end

	assign result.valid      = out_v_q;
	assign result.sample_out = out_q;

endmodule

// ----- src/cfd_step_mod.sv -----
// ----------------------------------------------------------------------------
// cfd_step_mod: integer part of the read step reduced modulo the length
// Restoring remainder, one dividend bit per cycle, with the floored
// correction for a negative step applied on the output.
// ----------------------------------------------------------------------------
module cfd_step_mod (
	input  logic              clk,
	input  logic              arst_n,
	input  cfd_pkg::mod_req_t req,
	output cfd_pkg::mod_rsp_t rsp
);
	import cfd_pkg::*;

	logic [CNT_BITS-1:0]  cnt_q;
	logic [INT_BITS-1:0]  mag_q;
	logic [ADDR_BITS-1:0] rem_q;
	logic                 neg_q;
	logic [LEN_BITS-1:0]  len_q;
	logic [LEN_BITS-1:0]  trial;
	logic [LEN_BITS-1:0]  rem_next;
	logic [LEN_BITS-1:0]  mirror;

	assign trial    = {rem_q, mag_q[INT_BITS-1]};
	assign rem_next = (trial >= len_q) ? (trial - len_q) : trial;
	assign mirror   = len_q - {1'b0, rem_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= CNT_BITS'(INT_BITS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.num[INT_BITS-1];
			mag_q <= req.num[INT_BITS-1] ? INT_BITS'(-req.num) : INT_BITS'(req.num);
			len_q <= req.len;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			mag_q <= {mag_q[INT_BITS-2:0], 1'b0};
			rem_q <= rem_next[ADDR_BITS-1:0];
		end
	end

	// floor the remainder toward the divisor for a negative step
	always_comb begin
		rsp.busy = (cnt_q != '0);
		if (neg_q && rem_q != '0) begin
			rsp.rem = mirror[ADDR_BITS-1:0];
		end else begin
			rsp.rem = rem_q;
		end
	end

endmodule
